// ===== rtl/xbve_pkg.sv =====
// shared types and code constants for the xor bucket value encoder
// no dependencies
package xbve_pkg;

   localparam int SAMPLE_W = 64;
   localparam int COUNT_W  = 6;
   localparam int LENGTH_W = 7;

   // header codes
   localparam logic [1:0] CODE_ZERO  = 2'b11;
   localparam logic [1:0] CODE_REUSE = 2'b10;
   localparam logic       CODE_NEW   = 1'b0;

   // field prefixes for the new window header
   localparam logic [1:0] PREFIX_MID = 2'b10;
   localparam logic [1:0] PREFIX_ESC = 2'b11;

   // window counts after reset
   localparam logic [LENGTH_W-1:0] WINDOW_RESET = 7'd64;

   typedef struct packed {
      logic [SAMPLE_W-1:0] x;
      logic [COUNT_W-1:0]  lz;
      logic [COUNT_W-1:0]  tz;
      logic                zero;
   } counted_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] bits;
      logic [LENGTH_W-1:0] length;
      logic                last;
   } chunk_type;

   typedef struct packed {
      chunk_type head;
      chunk_type body;
      logic      two;
   } encoded_type;

endpackage

// ===== rtl/xor_bucket_value_encoder.sv =====
// xor bucket value encoder, top level
// the first chunk is shown from the result register, behind the xor and count stages
// output gives one chunk a cycle while rsp_stall is low; a request with a payload chunk
// holds the result register until its payload is taken, so the rate is one request per
// cycle for single chunk codes, and the next request waits while a payload follows
// reset clears all valids, the previous sample to zero and both window counts to 64
// depends on xbve_pkg, xbve_zero_count, xbve_encoder, xbve_chunk_out
module xor_bucket_value_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_sample_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_code_bits,
   output logic [6:0]  rsp_code_length,
   output logic        rsp_last_of_value
);
   import xbve_pkg::*;

   // previous sample, updated as each request enters
   logic [63:0] prev_ff, prev_in;

   // xor stage
   logic        x_valid_ff, x_valid_in;
   logic [63:0] x_ff, x_in;

   // stored window: leading and trailing zero counts of the last non-zero xor
   logic [6:0]  plz_ff, plz_in;
   logic [6:0]  ptz_ff, ptz_in;

   logic        req_take;
   logic        cnt_ready;
   logic        cnt_valid;
   counted_type cnt;
   encoded_type enc;
   logic        out_ready;
   logic        cnt_take;
   chunk_type   chunk;

   // the xor stage moves on whenever the count stage has room
   assign req_stall = x_valid_ff && !cnt_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      prev_in    = prev_ff;
      x_in       = x_ff;
      x_valid_in = x_valid_ff && !cnt_ready;
      if (req_take) begin
         prev_in    = req_sample_value;
         x_in       = req_sample_value ^ prev_ff;
         x_valid_in = 1'b1;
      end
   end

   xbve_zero_count u_count (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (x_valid_ff),
      .load_x      (x_ff),
      .load_ready  (cnt_ready),
      .drain_ready (out_ready),
      .cnt_valid   (cnt_valid),
      .cnt         (cnt)
   );

   // encoding sits between the count register and the result register
   xbve_encoder u_encoder (
      .cnt (cnt),
      .plz (plz_ff),
      .ptz (ptz_ff),
      .enc (enc)
   );

   // window follows the request that enters the result register;
   // a zero xor leaves it as it is
   assign cnt_take = cnt_valid && out_ready;

   always_comb begin
      plz_in = plz_ff;
      ptz_in = ptz_ff;
      if (cnt_take && !cnt.zero) begin
         plz_in = {1'b0, cnt.lz};
         ptz_in = {1'b0, cnt.tz};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         x_valid_ff <= 1'b0;
         plz_ff     <= WINDOW_RESET;
         ptz_ff     <= WINDOW_RESET;
      end else begin
         prev_ff    <= prev_in;
         x_valid_ff <= x_valid_in;
         plz_ff     <= plz_in;
         ptz_ff     <= ptz_in;
      end
      x_ff <= x_in;
   end

   xbve_chunk_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (cnt_valid),
      .load_enc   (enc),
      .load_ready (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_chunk  (chunk)
   );

   assign rsp_code_bits     = chunk.bits;
   assign rsp_code_length   = chunk.length;
   assign rsp_last_of_value = chunk.last;

   // every chunk shown carries at least one bit and no more than 64
   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_code_length != 7'd0 && rsp_code_length <= 7'd64))
      else $error("chunk length out of range");

   // after a non-zero xor the stored window holds real counts
   a_window_set: assert property (@(posedge clock) disable iff (reset)
      (cnt_take && !cnt.zero) |=> (plz_ff <= 7'd63 && ptz_ff <= 7'd63))
      else $error("window counts not updated");

endmodule

// ===== rtl/xbve_zero_count.sv =====
// count stage: registers the xor word with its leading and trailing zero counts
// depends on xbve_pkg
module xbve_zero_count (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load_valid,
   input  logic [63:0]               load_x,
   output logic                      load_ready,
   input  logic                      drain_ready,
   output logic                      cnt_valid,
   output xbve_pkg::counted_type     cnt
);
   import xbve_pkg::*;

   logic        valid_ff, valid_in;
   counted_type cnt_ff, cnt_in;
   logic [63:0] lv, tv;
   logic [5:0]  lz, tz;

   // binary search for leading zeros
   always_comb begin
      lv = load_x;
      lz = '0;
      if (lv[63:32] == 32'd0) begin
         lz[5] = 1'b1;
         lv = lv << 32;
      end
      if (lv[63:48] == 16'd0) begin
         lz[4] = 1'b1;
         lv = lv << 16;
      end
      if (lv[63:56] == 8'd0) begin
         lz[3] = 1'b1;
         lv = lv << 8;
      end
      if (lv[63:60] == 4'd0) begin
         lz[2] = 1'b1;
         lv = lv << 4;
      end
      if (lv[63:62] == 2'd0) begin
         lz[1] = 1'b1;
         lv = lv << 2;
      end
      if (lv[63] == 1'b0) begin
         lz[0] = 1'b1;
      end
   end

   // and for trailing zeros
   always_comb begin
      tv = load_x;
      tz = '0;
      if (tv[31:0] == 32'd0) begin
         tz[5] = 1'b1;
         tv = tv >> 32;
      end
      if (tv[15:0] == 16'd0) begin
         tz[4] = 1'b1;
         tv = tv >> 16;
      end
      if (tv[7:0] == 8'd0) begin
         tz[3] = 1'b1;
         tv = tv >> 8;
      end
      if (tv[3:0] == 4'd0) begin
         tz[2] = 1'b1;
         tv = tv >> 4;
      end
      if (tv[1:0] == 2'd0) begin
         tz[1] = 1'b1;
         tv = tv >> 2;
      end
      if (tv[0] == 1'b0) begin
         tz[0] = 1'b1;
      end
   end

   assign load_ready = !valid_ff || drain_ready;

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      if (load_ready) begin
         valid_in    = load_valid;
         cnt_in.x    = load_x;
         cnt_in.lz   = lz;
         cnt_in.tz   = tz;
         cnt_in.zero = (load_x == 64'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cnt_ff <= cnt_in;
   end

   assign cnt_valid = valid_ff;
   assign cnt       = cnt_ff;

endmodule

// ===== rtl/xbve_encoder.sv =====
// code builder: header and payload chunks from the counts and the stored window
// depends on xbve_pkg
module xbve_encoder (
   input  xbve_pkg::counted_type  cnt,
   input  logic [6:0]             plz,
   input  logic [6:0]             ptz,
   output xbve_pkg::encoded_type  enc
);
   import xbve_pkg::*;

   typedef struct packed {
      logic [7:0] code;
      logic [3:0] len;
   } field_type;

   function automatic field_type code_field(input logic [8:0] zz, input logic [5:0] esc);
      field_type f;
      if (zz < 9'd4) begin
         f.code = {6'd0, zz[1:0]};
         f.len  = 4'd3;
      end else if (zz < 9'd16) begin
         f.code = {2'd0, PREFIX_MID, zz[3:0]};
         f.len  = 4'd6;
      end else begin
         f.code = {PREFIX_ESC, esc};
         f.len  = 4'd8;
      end
      return f;
   endfunction

   logic        reuse;
   logic [6:0]  reuse_sig;
   logic [6:0]  sum_new;
   logic [7:0]  sum_old;
   logic [7:0]  da, db;
   logic [8:0]  zza, zzb;
   logic [5:0]  w;
   field_type   fa, fb;
   logic [16:0] hdr;
   logic [6:0]  hdr_len;
   logic [63:0] shifted;
   logic [63:0] keep;

   assign reuse     = ({1'b0, cnt.lz} >= plz) && ({1'b0, cnt.tz} >= ptz);
   assign reuse_sig = WINDOW_RESET - plz - ptz;

   // signed deltas, zigzag on the narrow form
   assign sum_new = {1'b0, cnt.lz} + {1'b0, cnt.tz};
   assign sum_old = {1'b0, plz} + {1'b0, ptz};
   assign da      = {2'b00, cnt.lz} - {1'b0, plz};
   assign db      = {1'b0, sum_new} - sum_old;
   assign zza     = {da, 1'b0} ^ {9{da[7]}};
   assign zzb     = {db, 1'b0} ^ {9{db[7]}};

   // significant width minus one
   assign w = 6'd63 - cnt.lz - cnt.tz;

   assign fa      = code_field(zza, cnt.lz);
   assign fb      = code_field(zzb, w);
   assign hdr     = ({9'd0, fa.code} << fb.len) | {9'd0, fb.code};
   assign hdr_len = 7'd1 + {3'd0, fa.len} + {3'd0, fb.len};

   assign shifted = cnt.x >> cnt.tz;
   assign keep    = ~({64{1'b1}} << w);

   always_comb begin
      enc = '0;
      if (cnt.zero) begin
         enc.head.bits   = {62'd0, CODE_ZERO};
         enc.head.length = 7'd2;
         enc.head.last   = 1'b1;
         enc.two         = 1'b0;
      end else if (reuse) begin
         enc.head.bits   = {62'd0, CODE_REUSE};
         enc.head.length = 7'd2;
         enc.head.last   = 1'b0;
         enc.body.bits   = cnt.x >> ptz;
         enc.body.length = reuse_sig;
         enc.body.last   = 1'b1;
         enc.two         = 1'b1;
      end else begin
         // leading bit of the 17 bit header is the new window marker
         enc.head.bits   = {47'd0, hdr | {CODE_NEW, 16'd0}};
         enc.head.length = hdr_len;
         enc.head.last   = (w == 6'd0);
         enc.body.bits   = shifted & keep;
         enc.body.length = {1'b0, w};
         enc.body.last   = 1'b1;
         enc.two         = (w != 6'd0);
      end
   end

endmodule

// ===== rtl/xbve_chunk_out.sv =====
// result register: holds one encoded request and hands out its one or two chunks
// depends on xbve_pkg
module xbve_chunk_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_valid,
   input  xbve_pkg::encoded_type  load_enc,
   output logic                   load_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output xbve_pkg::chunk_type    rsp_chunk
);
   import xbve_pkg::*;

   logic        full_ff, full_in;
   logic        phase_ff, phase_in;
   encoded_type enc_ff, enc_in;
   logic        take;
   logic        shown_last;

   assign shown_last = phase_ff || !enc_ff.two;
   assign take       = full_ff && !rsp_stall;
   assign load_ready = !full_ff || (take && shown_last);

   always_comb begin
      full_in  = full_ff;
      phase_in = phase_ff;
      enc_in   = enc_ff;
      if (load_ready) begin
         full_in  = load_valid;
         phase_in = 1'b0;
         enc_in   = load_enc;
      end else if (take) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         full_ff  <= full_in;
         phase_ff <= phase_in;
      end
      enc_ff <= enc_in;
   end

   assign rsp_valid = full_ff;
   assign rsp_chunk = phase_ff ? enc_ff.body : enc_ff.head;

   // payload phase only while a request is held
   a_phase_full: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> full_ff)
      else $error("payload phase without held request");

   // a header that is not last is followed by its payload
   a_body_follows: assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_chunk.last) |=> (rsp_valid && phase_ff))
      else $error("payload chunk lost after header");

endmodule
